// ===== sv/mau_pkg.sv =====
package mau_pkg;

    localparam int ResW = 30;
    localparam int ExpW = 63;
    // divider numerator: wide enough for a full product and for a raw operand_b
    localparam int NumW = (2 * ResW > ExpW) ? 2 * ResW : ExpW;
    localparam logic [ResW-1:0] ModulusReset = 30'd998244353;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_POW = 3'd3,
        CMD_INV = 3'd4,
        CMD_DIV = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_DISPATCH,
        ST_MUL,
        ST_POW_STEP,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_INV_DIV,
        ST_INV_UPD,
        ST_INV_FIX,
        ST_DIV_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic [NumW-1:0] num;
    } red_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [NumW-1:0] quot;
        logic [ResW-1:0] rem;
    } red_rsp_t;

endpackage

// ===== sv/mau_divider.sv =====
// restoring divider, one quotient bit per cycle
module mau_divider
    import mau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  red_req_t         req,
    input  logic [ResW-1:0]  den,
    output red_rsp_t         rsp
);

    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] num_reg;
    logic [ResW:0]   rem_reg;
    logic [CntW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [ResW+1:0] trial;
    logic [ResW:0]   shifted;

    assign shifted = {rem_reg[ResW-1:0], num_reg[NumW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(NumW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[ResW+1])
            begin
                rem_reg <= trial[ResW:0];
                num_reg <= {num_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                num_reg <= {num_reg[NumW-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg[ResW-1:0];

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without work");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < {1'b0, den}) else $error("remainder out of range");
`endif

endmodule

// ===== sv/modular_arithmetic_unit.sv =====
// modular arithmetic unit: add, subtract, multiply, power, inverse and divide
// modulo a 30-bit modulus. a command is taken when start is high and busy is
// low; busy stays high until the result is shown for one cycle with done.
// the receiver cannot stall, so done is a single-cycle strobe. all divisions
// go through one shared restoring divider that yields one quotient bit a
// cycle, so the time per command is set by how many times that divider runs:
// twice for add and subtract, three times for multiply, once per euclid step
// after the two operand reductions for inverse, and up to twice per exponent
// bit for power. the modulus may be written only while busy is low.
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        cmd,
    input  logic [ResW-1:0]   operand_a,
    input  logic [ExpW-1:0]   operand_b,
    output logic              done,
    output logic [ResW-1:0]   result,
    input  logic              modulus_we,
    input  logic [ResW-1:0]   modulus_wdata
);

    localparam int SW   = ResW + 2;

    state_t state_reg, state_next;

    // configuration
    logic [ResW-1:0] modulus_reg;

    // operand and working registers
    logic [2:0]       cmd_reg;
    logic [ResW-1:0]  a_reg;
    logic [ResW-1:0]  b_reg;
    logic [ExpW-1:0]  exp_reg;
    logic [ResW-1:0]  acc_reg;
    logic [ResW-1:0]  res_reg;
    logic             done_reg;

    // euclid registers: remainders and signed coefficients
    logic [ResW-1:0]  r0_reg, r1_reg;
    logic signed [SW-1:0] s0_reg, s1_reg;

    // divider interface
    red_req_t         dreq;
    red_rsp_t         drsp;
    logic [ResW-1:0]  dden;

    mau_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .den   (dden),
        .rsp   (drsp)
    );

    logic mod_ok;
    assign mod_ok = (modulus_reg >= ResW'(2));

    // the product feeding the divider, selected by state
    logic [2*ResW-1:0] prod;
    logic [ResW-1:0] mul_x, mul_y;
    always_comb
    begin
        mul_x = a_reg;
        mul_y = b_reg;
        case (state_reg)
            ST_POW_MUL: begin mul_x = acc_reg; mul_y = a_reg; end
            ST_POW_SQR: begin mul_x = a_reg;   mul_y = a_reg; end
            ST_DIV_MUL: begin mul_x = a_reg;   mul_y = acc_reg; end
            default:    begin mul_x = a_reg;   mul_y = b_reg; end
        endcase
    end
    assign prod = mul_x * mul_y;

    // euclid update arithmetic: q fits in 30 bits since r0 < 2^30
    logic [ResW-1:0]      q_w;
    logic signed [SW+ResW:0] qs_w;
    logic signed [SW-1:0] snew_w;
    logic [ResW:0]        sum_ab;
    logic [ResW:0]        dif_ab;
    assign q_w    = drsp.quot[ResW-1:0];
    assign qs_w   = $signed({1'b0, q_w}) * s1_reg;
    assign snew_w = s0_reg - qs_w[SW-1:0];
    assign sum_ab = {1'b0, a_reg} + {1'b0, b_reg};
    assign dif_ab = {1'b0, a_reg} - {1'b0, b_reg};

    // divider request per state
    logic div_go;
    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num   = '0;
        dden       = modulus_reg;
        div_go     = !drsp.busy && !drsp.done;
        case (state_reg)
            ST_RED_A:
            begin
                dreq.start = div_go;
                dreq.num   = NumW'(a_reg);
            end
            ST_RED_B:
            begin
                dreq.start = div_go;
                dreq.num   = NumW'(exp_reg);
            end
            ST_MUL, ST_POW_MUL, ST_POW_SQR, ST_DIV_MUL:
            begin
                dreq.start = div_go;
                dreq.num   = NumW'(prod);
            end
            ST_INV_DIV:
            begin
                dreq.start = div_go && (r1_reg != '0);
                dreq.num   = NumW'(r0_reg);
                dden       = r1_reg;
            end
            ST_INV_UPD:
            begin
                dden = r1_reg;
            end
            default:
            begin
                dreq.start = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = mod_ok ? ST_RED_A : ST_DONE;
            ST_RED_A:
                if (drsp.done)
                    state_next = ST_RED_B;
            ST_RED_B:
                if (drsp.done)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
                case (cmd_reg)
                    CMD_MUL: state_next = ST_MUL;
                    CMD_POW: state_next = (a_reg <= ResW'(1)) ? ST_DONE : ST_POW_STEP;
                    CMD_INV, CMD_DIV: state_next = ST_INV_DIV;
                    default: state_next = ST_DONE;
                endcase
            ST_MUL:
                if (drsp.done)
                    state_next = ST_DONE;
            ST_POW_STEP:
                if (exp_reg == '0)
                    state_next = ST_DONE;
                else if (exp_reg[0])
                    state_next = ST_POW_MUL;
                else
                    state_next = ST_POW_SQR;
            ST_POW_MUL:
                if (drsp.done)
                    state_next = (exp_reg[ExpW-1:1] == '0) ? ST_DONE : ST_POW_SQR;
            ST_POW_SQR:
                if (drsp.done)
                    state_next = ST_POW_STEP;
            ST_INV_DIV:
                if (r1_reg == '0)
                    state_next = ST_INV_FIX;
                else if (drsp.done)
                    state_next = ST_INV_UPD;
            ST_INV_UPD:
                state_next = ST_INV_DIV;
            ST_INV_FIX:
                state_next = (cmd_reg == CMD_DIV) ? ST_DIV_MUL : ST_DONE;
            ST_DIV_MUL:
                if (drsp.done)
                    state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy   = (state_reg != ST_IDLE);
        done   = done_reg;
        result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            modulus_reg <= ModulusReset;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
            if (modulus_we)
                modulus_reg <= modulus_wdata;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    cmd_reg <= cmd;
                    a_reg   <= operand_a;
                    exp_reg <= operand_b;
                    b_reg   <= '0;
                    acc_reg <= ResW'(1);
                    res_reg <= '0;
                end
            ST_RED_A:
                if (drsp.done)
                    a_reg <= drsp.rem;
            ST_RED_B:
                if (drsp.done)
                    b_reg <= drsp.rem;
            ST_DISPATCH:
            begin
                r1_reg <= modulus_reg;
                s0_reg <= SW'(1);
                s1_reg <= '0;
                r0_reg <= (cmd_reg == CMD_DIV) ? b_reg : a_reg;
                case (cmd_reg)
                    CMD_ADD:
                        res_reg <= (sum_ab >= {1'b0, modulus_reg})
                                   ? ResW'(sum_ab - {1'b0, modulus_reg})
                                   : sum_ab[ResW-1:0];
                    CMD_SUB:
                        res_reg <= (a_reg >= b_reg) ? dif_ab[ResW-1:0]
                                   : ResW'(dif_ab + {1'b0, modulus_reg});
                    CMD_POW:
                        res_reg <= (a_reg <= ResW'(1) && exp_reg != '0) ? a_reg
                                   : ResW'(1);
                    default:
                        res_reg <= '0;
                endcase
            end
            ST_MUL, ST_DIV_MUL:
                if (drsp.done)
                    res_reg <= drsp.rem;
            ST_POW_STEP:
                if (exp_reg == '0)
                    res_reg <= acc_reg;
            ST_POW_MUL:
                if (drsp.done)
                begin
                    acc_reg <= drsp.rem;
                    res_reg <= drsp.rem;
                end
            // squaring consumes the current exponent bit
            ST_POW_SQR:
                if (drsp.done)
                begin
                    a_reg   <= drsp.rem;
                    exp_reg <= exp_reg >> 1;
                end
            ST_INV_UPD:
            begin
                r0_reg <= r1_reg;
                r1_reg <= drsp.rem;
                s0_reg <= s1_reg;
                s1_reg <= snew_w;
            end
            ST_INV_FIX:
            begin
                // |s0| stays below the modulus, so one correction suffices
                if (s0_reg < 0)
                    acc_reg <= ResW'(s0_reg + $signed({2'b00, modulus_reg}));
                else if (s0_reg >= $signed({2'b00, modulus_reg}))
                    acc_reg <= ResW'(s0_reg - $signed({2'b00, modulus_reg}));
                else
                    acc_reg <= s0_reg[ResW-1:0];
                if (cmd_reg == CMD_INV)
                begin
                    if (s0_reg < 0)
                        res_reg <= ResW'(s0_reg + $signed({2'b00, modulus_reg}));
                    else if (s0_reg >= $signed({2'b00, modulus_reg}))
                        res_reg <= ResW'(s0_reg - $signed({2'b00, modulus_reg}));
                    else
                        res_reg <= s0_reg[ResW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held for two cycles");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_DONE)) else $error("done without command");
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && mod_ok |-> res_reg < modulus_reg) else $error("result out of range");
    a_idle_no_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !dreq.start) else $error("divider used while idle");
`endif

endmodule
